// ===== sv/pip_pkg.sv =====
`timescale 1ns / 1ps
// Package for the point-in-polygon crossing test: sizes, op codes, queue entry
// and sequencer state types. No dependencies.
package pip_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_WIDTH  = 16;
   localparam int SLOT_W       = 8;
   localparam int CFG_W        = 9;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int NUM_W        = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic {
      OP_WRITE,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [SLOT_W-1:0]       slot;
      logic [COORD_WIDTH-1:0]  x;
      logic [COORD_WIDTH-1:0]  y;
      logic                    last;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== sv/pip_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/pip_fifo.sv =====
`timescale 1ns / 1ps
// Short request queue between the front and back parts.
// Depends on pip_pkg for the entry type and depth.
module pip_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pip_pkg::entry_type push_entry,
   input  logic               pop,
   output pip_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import pip_pkg::*;

   entry_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wptr_ff, wptr_in;
   logic [FIFO_AW-1:0]   rptr_ff, rptr_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + FIFO_AW'(1) : wptr_ff;
      rptr_in = pop  ? rptr_ff + FIFO_AW'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("request pushed into full queue");
`endif

endmodule

// ===== sv/pip_front.sv =====
`timescale 1ns / 1ps
// Front part: takes requests, decodes the command and drops out-of-range writes.
// Depends on pip_pkg; feeds pip_fifo.
module pip_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [pip_pkg::SLOT_W-1:0]        req_vertex_index,
   input  logic signed [pip_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [pip_pkg::COORD_WIDTH-1:0] req_coord_y,
   input  logic                              req_batch_last,
   input  logic                              fifo_full,
   output logic                              push,
   output pip_pkg::entry_type                push_entry
);
   import pip_pkg::*;

   logic      stage_vld_ff, stage_vld_in;
   logic      keep_ff, keep_in;
   entry_type stage_ff, stage_in;
   logic      accept;
   logic      go;
   logic      in_range;

   // a write to a slot beyond the store is dropped here
   assign in_range = (32'(req_vertex_index) < 32'(MAX_VERTICES));
   assign go        = stage_vld_ff && (!keep_ff || !fifo_full);
   assign push      = stage_vld_ff && keep_ff && !fifo_full;
   assign req_ready = !stage_vld_ff || go;
   assign accept    = req_valid && req_ready;
   assign push_entry = stage_ff;

   always_comb begin
      stage_in     = stage_ff;
      keep_in      = keep_ff;
      stage_vld_in = stage_vld_ff;
      if (accept) begin
         stage_in.op   = (req_cmd == CMD_QUERY) ? OP_QUERY : OP_WRITE;
         stage_in.slot = req_vertex_index;
         stage_in.x    = req_coord_x;
         stage_in.y    = req_coord_y;
         stage_in.last = req_batch_last;
         keep_in       = (req_cmd == CMD_QUERY) || in_range;
         stage_vld_in  = 1'b1;
      end else if (go) begin
         stage_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
      stage_ff <= stage_in;
      keep_ff  <= keep_in;
   end

endmodule

// ===== sv/pip_back.sv =====
`timescale 1ns / 1ps
// Back part: vertex store, edge walk sequencer, crossing pipeline, result register.
// Depends on pip_pkg and pip_ram.
module pip_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fifo_empty,
   input  pip_pkg::entry_type          fifo_head,
   output logic                        fifo_pop,
   input  logic [pip_pkg::CFG_W-1:0]   vertex_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_inside_res,
   output logic                        rsp_batch_end
);
   import pip_pkg::*;

   state_type state_ff, state_in;

   logic [NUM_W-1:0] n_ff, n_in, n_sat;
   logic [NUM_W-1:0] k_ff, k_in;
   logic signed [COORD_WIDTH-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic last_ff, last_in;
   logic parity_ff, parity_in;

   // read tags, aligned with registered RAM data
   logic t1_vld_ff, t1_vld_in, t1_edge_ff, t1_edge_in, t1_last_ff, t1_last_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   // difference stage
   logic s2_vld_ff, s2_vld_in, s2_last_ff, s2_last_in, s2_str_ff, s2_str_in;
   logic signed [DIFF_W-1:0] s2_dxa_ff, s2_dxa_in, s2_dy_ff, s2_dy_in;
   logic signed [DIFF_W-1:0] s2_dxb_ff, s2_dxb_in, s2_dyp_ff, s2_dyp_in;

   // product stage
   logic s3_vld_ff, s3_vld_in, s3_last_ff, s3_last_in;
   logic s3_str_ff, s3_str_in, s3_dir_ff, s3_dir_in;
   logic signed [PROD_W-1:0] s3_pa_ff, s3_pa_in, s3_pb_ff, s3_pb_in;

   logic rsp_vld_ff, rsp_vld_in, rsp_inside_ff, rsp_inside_in, rsp_end_ff, rsp_end_in;

   logic ram_we, rd_en, start, load_rsp, toggle;
   logic [ADDR_W-1:0] rd_addr;
   logic [2*COORD_WIDTH-1:0] rd_data;
   logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
   logic signed [DIFF_W-1:0] qx_e, qy_e, cx_e, cy_e, px_e, py_e;

   pip_ram #(
      .WIDTH (2*COORD_WIDTH),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(fifo_head.slot)),
      .wdata ({fifo_head.x, fifo_head.y}),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign n_sat = (32'(vertex_count) > 32'(MAX_VERTICES)) ? NUM_W'(MAX_VERTICES)
                                                          : NUM_W'(vertex_count);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty && fifo_head.op == OP_QUERY) begin
               state_in = (n_sat == '0) ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (k_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s3_vld_ff && s3_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      fifo_pop = 1'b0;
      rd_en    = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE:  fifo_pop = !fifo_empty;
         ST_WALK:  rd_en    = 1'b1;
         ST_DONE:  load_rsp = !rsp_vld_ff || rsp_ready;
         default: ;
      endcase
      ram_we = fifo_pop && (fifo_head.op == OP_WRITE);
      start  = fifo_pop && (fifo_head.op == OP_QUERY);
   end

   // walk order: last vertex first, then vertex 0 up to the last again
   assign rd_addr = (k_ff == '0) ? ADDR_W'(n_ff - NUM_W'(1)) : ADDR_W'(k_ff - NUM_W'(1));

   assign cur_x = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign cur_y = rd_data[COORD_WIDTH-1:0];
   assign qx_e  = DIFF_W'(qx_ff);
   assign qy_e  = DIFF_W'(qy_ff);
   assign cx_e  = DIFF_W'(cur_x);
   assign cy_e  = DIFF_W'(cur_y);
   assign px_e  = DIFF_W'(prev_x_ff);
   assign py_e  = DIFF_W'(prev_y_ff);

   // downward edges (previous vertex higher) test a < b, upward edges the mirrored a > b
   assign toggle = s3_str_ff && (s3_dir_ff ? (s3_pa_ff < s3_pb_ff) : (s3_pa_ff > s3_pb_ff));

   always_comb begin
      n_in   = start ? n_sat : n_ff;
      k_in   = start ? '0 : (rd_en ? k_ff + NUM_W'(1) : k_ff);
      qx_in  = start ? signed'(fifo_head.x) : qx_ff;
      qy_in  = start ? signed'(fifo_head.y) : qy_ff;
      last_in = start ? fifo_head.last : last_ff;
      parity_in = start ? 1'b0 : (s3_vld_ff ? parity_ff ^ toggle : parity_ff);

      t1_vld_in  = rd_en;
      t1_edge_in = (k_ff != '0);
      t1_last_in = (k_ff == n_ff);
      prev_x_in  = t1_vld_ff ? cur_x : prev_x_ff;
      prev_y_in  = t1_vld_ff ? cur_y : prev_y_ff;

      // edge runs from the previous vertex (j) to the current one (i)
      s2_vld_in  = t1_vld_ff && t1_edge_ff;
      s2_last_in = t1_last_ff;
      s2_str_in  = ((cur_y <= qy_ff) && (qy_ff < prev_y_ff)) ||
                   ((prev_y_ff <= qy_ff) && (qy_ff < cur_y));
      s2_dxa_in  = qx_e - cx_e;
      s2_dy_in   = py_e - cy_e;
      s2_dxb_in  = px_e - cx_e;
      s2_dyp_in  = qy_e - cy_e;

      s3_vld_in  = s2_vld_ff;
      s3_last_in = s2_last_ff;
      s3_str_in  = s2_str_ff;
      s3_dir_in  = (s2_dy_ff > 0);
      s3_pa_in   = PROD_W'(s2_dxa_ff) * PROD_W'(s2_dy_ff);
      s3_pb_in   = PROD_W'(s2_dxb_ff) * PROD_W'(s2_dyp_ff);

      rsp_vld_in    = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
      rsp_inside_in = load_rsp ? parity_ff : rsp_inside_ff;
      rsp_end_in    = load_rsp ? last_ff : rsp_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         parity_ff  <= 1'b0;
         t1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         k_ff       <= '0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         parity_ff  <= parity_in;
         t1_vld_ff  <= t1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         k_ff       <= k_in;
         n_ff       <= n_in;
      end
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      last_ff       <= last_in;
      t1_edge_ff    <= t1_edge_in;
      t1_last_ff    <= t1_last_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      s2_last_ff    <= s2_last_in;
      s2_str_ff     <= s2_str_in;
      s2_dxa_ff     <= s2_dxa_in;
      s2_dy_ff      <= s2_dy_in;
      s2_dxb_ff     <= s2_dxb_in;
      s2_dyp_ff     <= s2_dyp_in;
      s3_last_ff    <= s3_last_in;
      s3_str_ff     <= s3_str_in;
      s3_dir_ff     <= s3_dir_in;
      s3_pa_ff      <= s3_pa_in;
      s3_pb_ff      <= s3_pb_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_batch_end  = rsp_end_ff;

`ifndef ASSERT_OFF
   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("vertex write during a query walk");

   a_last_edge_done: assert property (@(posedge clock) disable iff (reset)
      (s3_vld_ff && s3_last_ff) |=> (state_ff == ST_DONE))
      else $error("final edge did not close the walk");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (32'(rd_addr) < 32'(n_ff)))
      else $error("walk read beyond vertex count");
`endif

endmodule

// ===== sv/point_in_polygon_crossing_test_top.sv =====
`timescale 1ns / 1ps
// Even-odd ray-crossing point-in-polygon test. A request with cmd 0 writes one
// vertex into a 256-entry store and gives no response; a request with cmd 1 asks
// whether a point lies inside the polygon of the first vertex_count vertices and
// gives one response. The front stage decodes requests into a 4-deep queue, so
// requests keep flowing, until the queue fills, while the back end walks a polygon
// or a response waits. A vertex write is applied to the store as it is popped. A
// query is popped, then makes vertex_count + 1 reads from the store's single read
// port at one vertex per cycle (starting with the closing vertex), passes the
// registered read and the difference / multiply stages, and loads the response
// register; with vertex_count 0 it goes from the pop straight to the response.
// Queries never overlap: the next pops only after the last response is loaded.
// The crossing test is exact: no rounding at any coordinate. Write csr_wdata
// only while no query is in flight; counts above 256 are treated as 256, and
// vertices that are read must have been written first.
// Depends on pip_pkg, pip_front, pip_fifo, pip_back and pip_ram.
module point_in_polygon_crossing_test_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic [pip_pkg::SLOT_W-1:0]             req_vertex_index,
   input  logic signed [pip_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [pip_pkg::COORD_WIDTH-1:0] req_coord_y,
   input  logic                                   req_batch_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_inside_res,
   output logic                                   rsp_batch_end,
   input  logic                                   csr_we,
   input  logic [pip_pkg::CFG_W-1:0]              csr_wdata
);
   import pip_pkg::*;

   // vertex_count register; the back end saturates it when a query starts
   logic [CFG_W-1:0] count_ff, count_in;

   logic      push, pop, fifo_full, fifo_empty;
   entry_type push_entry, head;

   assign count_in = csr_we ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // decode and hold one request, drop writes beyond the store
   pip_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_batch_last   (req_batch_last),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decouple front and back so each stalls on its own
   pip_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (fifo_empty),
      .full       (fifo_full)
   );

   // apply writes in order and walk the polygon for each query
   pip_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_empty     (fifo_empty),
      .fifo_head      (head),
      .fifo_pop       (pop),
      .vertex_count   (count_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_inside_res (rsp_inside_res),
      .rsp_batch_end  (rsp_batch_end)
   );

endmodule

// ===== test/tb_point_in_polygon_crossing_test_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for point_in_polygon_crossing_test_top: vertex writes,
// point queries and vertex-count settings, checked against an exact crossing predictor.
// Depends on pip_pkg and the RTL of the block under test.
module tb_point_in_polygon_crossing_test_top;
   import pip_pkg::*;

   localparam int TOTAL_ITEMS   = 1250;
   localparam int TAIL_START    = TOTAL_ITEMS * 85 / 100;
   localparam int SETTLE_CYCLES = 16;    // covers queued vertex writes behind the last result
   localparam int STALL_LIMIT   = 4000;  // a full 256-vertex walk plus stalls, several times over

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;

   typedef struct {
      logic in_poly;
      logic batch_end;
   } answer_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_COUNT
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic              cmd;
      logic [SLOT_W-1:0] slot;
      coord_type         x;
      coord_type         y;
      logic              last;
      bit                known;
      logic              in_poly;
      logic [CFG_W-1:0]  count;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_cmd;
   logic [SLOT_W-1:0] req_vertex_index;
   coord_type         req_coord_x;
   coord_type         req_coord_y;
   logic              req_batch_last;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_inside_res;
   logic              rsp_batch_end;
   logic              csr_we;
   logic [CFG_W-1:0]  csr_wdata;

   // Predictor state: our own copy of the vertex store and the count register.
   coord_type        vx_mem [0:MAX_VERTICES-1];
   coord_type        vy_mem [0:MAX_VERTICES-1];
   logic [CFG_W-1:0] count_setting;

   answer_type   answers_due[$];
   answer_type   due;
   plan_row_type plan[$];

   // A directed row with a typed-in answer hands it to the monitor through these.
   bit   typed_known;
   logic typed_inside;

   bit quiet_tail;
   int items_sent;
   int idle_cycles;
   int mismatches;
   int results_seen;
   int vertex_writes;
   int queries_seen;
   int count_writes;

   point_in_polygon_crossing_test_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_batch_last   (req_batch_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_batch_end    (rsp_batch_end),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Does the rightward ray from (px, py) cross edge (i, j)? The crossing x is
   // never divided out: both sides are scaled by |yj - yi|, so the compare is
   // exact. Lower end of the edge counts, upper end does not; flat edges never do.
   function automatic bit edge_crosses(input coord_type px, py, xi, yi, xj, yj);
      diff_type dx;
      diff_type ex;
      diff_type span;
      diff_type rise;
      prod_type lhs;
      prod_type rhs;
      if (!(((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi))))
         return 1'b0;
      dx = px - xi;
      ex = xj - xi;
      if (yj > yi) begin
         span = yj - yi;
         rise = py - yi;
      end else begin
         span = yi - yj;
         rise = yi - py;
      end
      lhs = dx * span;
      rhs = ex * rise;
      return lhs < rhs;
   endfunction

   // Even-odd parity over all edges, starting with the closing edge (n-1, 0).
   function automatic logic point_inside(input coord_type px, py);
      int   n;
      int   i;
      int   j;
      logic parity;
      n = (count_setting > MAX_VERTICES) ? MAX_VERTICES : int'(count_setting);
      parity = 1'b0;
      j = n - 1;
      for (i = 0; i < n; i++) begin
         if (edge_crosses(px, py, vx_mem[i], vy_mem[i], vx_mem[j], vy_mem[j]))
            parity = ~parity;
         j = i;
      end
      return parity;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: check results, then fold accepted requests into the predictor
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         // Check the result first so that a request accepted at the same edge
         // cannot satisfy it.
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no query outstanding",
                                         results_seen));
            end else begin
               due = answers_due.pop_front();
               if (rsp_inside_res !== due.in_poly)
                  report_mismatch($sformatf("result %0d inside_res: expected %0b, got %0b",
                                            results_seen, due.in_poly, rsp_inside_res));
               if (rsp_batch_end !== due.batch_end)
                  report_mismatch($sformatf("result %0d batch_end: expected %0b, got %0b",
                                            results_seen, due.batch_end, rsp_batch_end));
            end
         end
         if (csr_we) begin
            count_setting = csr_wdata;
            count_writes++;
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_WRITE) begin
               vx_mem[req_vertex_index] = req_coord_x;
               vy_mem[req_vertex_index] = req_coord_y;
               vertex_writes++;
            end else begin
               due.in_poly   = typed_known ? typed_inside
                                           : point_inside(req_coord_x, req_coord_y);
               due.batch_end = req_batch_last;
               answers_due.push_back(due);
               queries_seen++;
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || csr_we)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Drop the run when nothing has moved for too long.
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side: random bursts of back-pressure, none in the tail
   // ---------------------------------------------------------------------------

   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         if (quiet_tail || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   function automatic coord_type rand_coord(input int scale);
      int v;
      case (scale)
         0:       v = int'($urandom_range(0, 31)) - 16;     // dense: lots of collinear hits
         1:       v = int'($urandom_range(0, 1999)) - 1000;
         default: v = $urandom;                             // full 16-bit range
      endcase
      return coord_type'(v);
   endfunction

   function automatic void add_req(input logic cmd, input logic [SLOT_W-1:0] slot,
                                   input coord_type x, y, input logic last,
                                   input bit known, input logic in_poly);
      plan_row_type r;
      r.kind    = ROW_REQUEST;
      r.cmd     = cmd;
      r.slot    = slot;
      r.x       = x;
      r.y       = y;
      r.last    = last;
      r.known   = known;
      r.in_poly = in_poly;
      r.count   = '0;
      plan.push_back(r);
   endfunction

   function automatic void add_count(input logic [CFG_W-1:0] count);
      plan_row_type r;
      r.kind    = ROW_COUNT;
      r.cmd     = CMD_WRITE;
      r.slot    = '0;
      r.x       = '0;
      r.y       = '0;
      r.last    = 1'b0;
      r.known   = 1'b0;
      r.in_poly = 1'b0;
      r.count   = count;
      plan.push_back(r);
   endfunction

   // Present one request at a falling edge and hold it until it is taken.
   // Called and returns at a falling edge; valid is left high for the next one.
   task automatic send_req(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input coord_type x, y, input logic last,
                           input bit known, input logic in_poly);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_cmd          <= cmd;
      req_vertex_index <= slot;
      req_coord_x      <= x;
      req_coord_y      <= y;
      req_batch_last   <= last;
      req_valid        <= 1'b1;
      typed_known  = known;
      typed_inside = in_poly;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      quiet_tail = (items_sent >= TAIL_START);
   endtask

   // Query a point: mostly near the polygon, often on a vertex's x or y so that
   // the inclusive/exclusive ends of edges get hit, sometimes anywhere.
   task automatic send_point(input int n, input int scale, input logic last);
      int        r;
      int        k;
      coord_type x;
      coord_type y;
      r = $urandom_range(0, 9);
      x = rand_coord(scale);
      y = rand_coord(scale);
      if (n > 0 && r < 4) begin
         k = $urandom_range(0, (n > MAX_VERTICES) ? MAX_VERTICES - 1 : n - 1);
         if (r < 2)
            x = vx_mem[k];
         y = vy_mem[k];
      end else if (r == 9) begin
         x = rand_coord(2);
         y = rand_coord(2);
      end
      send_req(CMD_QUERY, SLOT_W'($urandom), x, y, last, 1'b0, 1'b0);
   endtask

   // Hold off requests until every result is in and queued writes have retired.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(input logic [CFG_W-1:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------

   initial begin
      int   i;
      int   k;
      int   n;
      int   q;
      int   pick;
      int   scale;
      logic [CFG_W-1:0] count;
      plan_row_type row;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_WRITE;
      req_vertex_index = '0;
      req_coord_x      = '0;
      req_coord_y      = '0;
      req_batch_last   = 1'b0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      count_setting    = '0;
      typed_known      = 1'b0;
      typed_inside     = 1'b0;
      quiet_tail       = 1'b0;
      items_sent       = 0;
      mismatches       = 0;
      results_seen     = 0;
      vertex_writes    = 0;
      queries_seen     = 0;
      count_writes     = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Count is 0 after reset: every point is outside.
      add_req(CMD_QUERY, 8'd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0);
      add_req(CMD_QUERY, 8'd0, -16'sd32768, 16'sd32767, 1'b0, 1'b1, 1'b0);
      add_req(CMD_QUERY, 8'd255, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 1'b0);
      // Axis-aligned square: two flat edges that must never toggle.
      add_req(CMD_WRITE, 8'd0, -16'sd100, -16'sd100, 1'b0, 1'b0, 1'b0);
      add_req(CMD_WRITE, 8'd1, 16'sd100, -16'sd100, 1'b1, 1'b0, 1'b0);
      add_req(CMD_WRITE, 8'd2, 16'sd100, 16'sd100, 1'b0, 1'b0, 1'b0);
      add_req(CMD_WRITE, 8'd3, -16'sd100, 16'sd100, 1'b1, 1'b0, 1'b0);
      add_count(9'd4);
      add_req(CMD_QUERY, 8'd7, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1);
      add_req(CMD_QUERY, 8'd0, 16'sd200, 16'sd0, 1'b0, 1'b1, 1'b0);
      add_req(CMD_QUERY, 8'd0, -16'sd200, 16'sd0, 1'b0, 1'b1, 1'b0);
      // Corner and three sides of the square: ends and boundaries.
      add_req(CMD_QUERY, 8'd0, -16'sd100, -16'sd100, 1'b0, 1'b0, 1'b0);
      add_req(CMD_QUERY, 8'd0, 16'sd0, 16'sd100, 1'b0, 1'b0, 1'b0);
      add_req(CMD_QUERY, 8'd0, 16'sd100, 16'sd0, 1'b0, 1'b0, 1'b0);
      add_req(CMD_QUERY, 8'd0, 16'sd0, -16'sd100, 1'b1, 1'b0, 1'b0);
      // Triangle spanning the whole coordinate range; top slot gets an extreme too.
      add_req(CMD_WRITE, 8'd0, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0);
      add_req(CMD_WRITE, 8'd1, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 1'b0);
      add_req(CMD_WRITE, 8'd2, 16'sd0, 16'sd32767, 1'b0, 1'b0, 1'b0);
      add_req(CMD_WRITE, 8'd255, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 1'b0);
      add_count(9'd3);
      add_req(CMD_QUERY, 8'd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1);
      add_req(CMD_QUERY, 8'd0, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0);
      add_req(CMD_QUERY, 8'd0, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 1'b0);
      add_req(CMD_QUERY, 8'd0, 16'sd0, 16'sd32767, 1'b0, 1'b0, 1'b0);
      add_req(CMD_QUERY, 8'd0, -16'sd32768, 16'sd0, 1'b1, 1'b0, 1'b0);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_COUNT)
            write_count(row.count);
         else
            send_req(row.cmd, row.slot, row.x, row.y, row.last, row.known, row.in_poly);
      end

      // Fill the whole store once: every slot is defined from here on, so any
      // count is legal, including those above the store size that saturate.
      scale = $urandom_range(0, 2);
      for (k = 0; k < MAX_VERTICES; k++)
         send_req(CMD_WRITE, k[SLOT_W-1:0], rand_coord(scale), rand_coord(scale),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0);
      for (i = 0; i < 3; i++) begin
         case (i)
            0:       count = 9'd256;
            1:       count = 9'd511;
            default: count = CFG_W'(257 + $urandom_range(0, 253));
         endcase
         write_count(count);
         for (q = 0; q < 5; q++)
            send_point(MAX_VERTICES, scale, q == 4);
      end

      // Random polygons: load n vertices, set the count while idle, then query.
      n = MAX_VERTICES;
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            k = 0;
         else if (pick <= 2)
            k = $urandom_range(1, 2);
         else if (pick <= 4)
            k = $urandom_range(40, 120);
         else if (pick == 5)
            k = $urandom_range(200, MAX_VERTICES);
         else
            k = $urandom_range(3, 12);
         scale = $urandom_range(0, 2);

         // Load; a stray query now and then still sees the old count.
         for (i = 0; i < k; i++) begin
            send_req(CMD_WRITE, i[SLOT_W-1:0], rand_coord(scale), rand_coord(scale),
                     1'($urandom_range(0, 1)), 1'b0, 1'b0);
            if ($urandom_range(0, 9) == 0)
               send_point(n, scale, 1'($urandom_range(0, 1)));
         end
         n = k;
         if (n == MAX_VERTICES && $urandom_range(0, 1) == 1)
            count = CFG_W'(257 + $urandom_range(0, 254));
         else
            count = CFG_W'(n);
         write_count(count);

         q = $urandom_range(4, 20);
         for (i = 0; i < q; i++) begin
            // Move one vertex mid-stream; order in the block keeps it exact.
            if (n > 0 && $urandom_range(0, 9) == 0) begin
               k = $urandom_range(0, n - 1);
               send_req(CMD_WRITE, k[SLOT_W-1:0], rand_coord(scale), rand_coord(scale),
                        1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end
            // Let the pipe run dry before going on.
            if ($urandom_range(0, 14) == 0)
               wait_drained();
            send_point(n, scale, (i == q - 1) || ($urandom_range(0, 4) == 0));
         end
      end

      wait_drained();

      $display("Run covered %0d requests: %0d vertex writes and %0d point queries,",
               items_sent, vertex_writes, queries_seen);
      $display("over %0d vertex-count settings; %0d results checked, %0d mismatches.",
               count_writes, results_seen, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
